// File: rtl/rrqs_pkg.sv
package rrqs_pkg;

  // Default size of the task table
  localparam int TASK_SLOTS_DEF = 16;

  // Quantum of a task is this base minus its priority
  localparam logic [2:0] QUANTUM_BASE = 3'd4;

  // Request operation codes; code 3 carries no operation
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2
  } task_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] context_value;
    logic [1:0]  priority_req;
    logic [3:0]  task_select;
    logic        runnable;
  } req_t;

  typedef struct packed {
    logic [63:0] next_context;
    logic [3:0]  task_index;
    logic        status;
    logic        switched;
    logic [63:0] tick_count;
    logic [4:0]  task_count;
  } rsp_t;

  // One task table entry, minus the saved context
  typedef struct packed {
    task_state_t state;
    logic [1:0]  prio;
    logic [2:0]  quantum;
    logic [63:0] run_ticks;
  } meta_t;

  // Write enables of the two table memories
  typedef struct packed {
    logic meta_we;
    logic ctx_we;
  } wr_ctl_t;

  // Contents of entry 0 after reset
  localparam meta_t META_ENTRY0 = '{state: ST_RUNNING, prio: 2'd1, quantum: 3'd3,
                                   run_ticks: 64'd0};

  function automatic logic [2:0] quantum_for(logic [1:0] prio);
    return QUANTUM_BASE - {1'b0, prio};
  endfunction

endpackage

// File: rtl/rrqs_store.sv
module rrqs_store #(
  parameter int TASK_SLOTS = rrqs_pkg::TASK_SLOTS_DEF,
  localparam int IDX_W = $clog2(TASK_SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rrqs_pkg::wr_ctl_t     wr_ctl,
  input  logic [IDX_W-1:0]      wr_addr,
  input  rrqs_pkg::meta_t       wr_meta,
  input  logic [63:0]           wr_ctx,
  input  logic [IDX_W-1:0]      rd_addr,
  output rrqs_pkg::meta_t       rd_meta,
  output logic [63:0]           rd_ctx
);

  rrqs_pkg::meta_t meta_mem [TASK_SLOTS];
  logic [63:0]     ctx_mem [TASK_SLOTS];
  rrqs_pkg::meta_t meta_raw;
  logic            fresh;
  logic            rd_fresh;

  // Write and read both memories, read data registered
  always_ff @(posedge clk) begin
    if (wr_ctl.meta_we) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    if (wr_ctl.ctx_we) begin
      ctx_mem[wr_addr] <= wr_ctx;
    end
    meta_raw <= meta_mem[rd_addr];
    rd_ctx   <= ctx_mem[rd_addr];
  end

  // Track entry 0 until its first write; it reads as the reset entry meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh    <= 1'b1;
      rd_fresh <= 1'b0;
    end else begin
      if (wr_ctl.meta_we && wr_addr == '0) begin
        fresh <= 1'b0;
      end
      rd_fresh <= fresh && (rd_addr == '0);
    end
  end

  assign rd_meta = rd_fresh ? rrqs_pkg::META_ENTRY0 : meta_raw;

endmodule

// File: rtl/round_robin_quantum_scheduler.sv
// Tick with quantum left: the result is registered in the update state after the current entry is read.
// Tick with quantum expiring: the scan reads one table entry per cycle from the
//   table memory until it finds a task that is not blocked or has walked the table.
// Create, set-runnable and unused codes: the result is registered in the state that writes the table, if any.
// A new request is taken in the cycle its predecessor's result is shown.
// Reset (synchronous) clears control state; entry 0 reads as the running task
//   until first written, and the context memory is not cleared.
module round_robin_quantum_scheduler #(
  parameter int TASK_SLOTS = rrqs_pkg::TASK_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rrqs_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output rrqs_pkg::rsp_t result
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RD_CUR   = 10'b0000000010,
    S_UPD_CUR  = 10'b0000000100,
    S_SEARCH   = 10'b0000001000,
    S_SELF     = 10'b0000010000,
    S_FIN_CAND = 10'b0000100000,
    S_FIN_CUR  = 10'b0001000000,
    S_CREATE   = 10'b0010000000,
    S_SET_RD   = 10'b0100000000,
    S_SET_WR   = 10'b1000000000
  } state_t;

  state_t                state;
  rrqs_pkg::req_t        req;
  logic [IDX_W-1:0]      running;
  logic [IDX_W-1:0]      cur_idx;
  logic [CNT_W-1:0]      used;
  logic [63:0]           ticks_total;
  rrqs_pkg::meta_t       cur_word;
  logic [IDX_W-1:0]      cand_idx;
  rrqs_pkg::meta_t       cand_word;
  logic [63:0]           cand_ctx;
  logic [IDX_W-1:0]      scan_addr;
  logic [CNT_W-1:0]      left;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_addr;

  rrqs_pkg::wr_ctl_t     wr_ctl;
  logic [IDX_W-1:0]      wr_addr;
  rrqs_pkg::meta_t       wr_meta;
  logic [63:0]           wr_ctx;
  logic [IDX_W-1:0]      rd_addr;
  rrqs_pkg::meta_t       rd_meta;
  logic [63:0]           rd_ctx;

  rrqs_pkg::meta_t       bump_word;
  logic [IDX_W+3:0]      sel_ext;
  logic [IDX_W-1:0]      sel_idx;
  logic                  sel_ok;
  logic                  table_full;

  // Next slot in round-robin order over the used part of the table
  function automatic logic [IDX_W-1:0] step_idx(logic [IDX_W-1:0] a, logic [CNT_W-1:0] n);
    logic [CNT_W:0] a1;
    a1 = {{(CNT_W - IDX_W + 1){1'b0}}, a} + 1'b1;
    return (a1 == {1'b0, n}) ? '0 : a1[IDX_W-1:0];
  endfunction

  function automatic logic [3:0] to_idx4(logic [IDX_W-1:0] a);
    logic [IDX_W+3:0] e;
    e = {4'b0, a};
    return e[3:0];
  endfunction

  function automatic logic [4:0] to_cnt5(logic [CNT_W-1:0] n);
    logic [CNT_W+4:0] e;
    e = {5'b0, n};
    return e[4:0];
  endfunction

  rrqs_store #(.TASK_SLOTS(TASK_SLOTS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_meta (wr_meta),
    .wr_ctx  (wr_ctx),
    .rd_addr (rd_addr),
    .rd_meta (rd_meta),
    .rd_ctx  (rd_ctx)
  );

  assign busy = (state != S_IDLE);

  // Decode the selected task and the table fill
  always_comb begin
    sel_ext    = {{IDX_W{1'b0}}, req.task_select};
    sel_idx    = sel_ext[IDX_W-1:0];
    sel_ok     = ({{CNT_W{1'b0}}, req.task_select} < {4'b0, used});
    table_full = (used >= SLOTS_CNT);
    bump_word           = rd_meta;
    bump_word.run_ticks = rd_meta.run_ticks + 64'd1;
  end

  // Drive memory read and write ports per state
  always_comb begin
    wr_ctl  = '0;
    wr_addr = cur_idx;
    wr_meta = cur_word;
    wr_ctx  = req.context_value;
    rd_addr = scan_addr;
    unique case (state)
      S_RD_CUR: begin
        rd_addr       = running;
        wr_addr       = running;
        wr_ctl.ctx_we = 1'b1;
      end
      S_UPD_CUR: begin
        if (rd_meta.quantum > 3'd1) begin
          wr_ctl.meta_we  = 1'b1;
          wr_meta         = bump_word;
          wr_meta.quantum = rd_meta.quantum - 3'd1;
        end
      end
      S_SELF: begin
        wr_ctl.meta_we  = 1'b1;
        wr_meta.state   = (cur_word.state == rrqs_pkg::ST_BLOCKED) ?
                          rrqs_pkg::ST_BLOCKED : rrqs_pkg::ST_RUNNING;
        wr_meta.quantum = rrqs_pkg::quantum_for(cur_word.prio);
      end
      S_FIN_CAND: begin
        wr_ctl.meta_we  = 1'b1;
        wr_addr         = cand_idx;
        wr_meta         = cand_word;
        wr_meta.state   = rrqs_pkg::ST_RUNNING;
        wr_meta.quantum = rrqs_pkg::quantum_for(cand_word.prio);
      end
      S_FIN_CUR: begin
        wr_ctl.meta_we = 1'b1;
        wr_meta.state  = rrqs_pkg::ST_READY;
      end
      S_CREATE: begin
        if (!table_full) begin
          wr_ctl.meta_we = 1'b1;
          wr_ctl.ctx_we  = 1'b1;
          wr_addr        = used[IDX_W-1:0];
          wr_meta        = '{state: rrqs_pkg::ST_READY, prio: req.priority_req,
                             quantum: rrqs_pkg::quantum_for(req.priority_req),
                             run_ticks: 64'd0};
        end
      end
      S_SET_RD: begin
        rd_addr = sel_idx;
      end
      S_SET_WR: begin
        // Only a set-runnable request writes; the unused code passes through
        if (sel_ok && req.operation == rrqs_pkg::OP_SET) begin
          wr_ctl.meta_we = 1'b1;
          wr_addr        = sel_idx;
          wr_meta        = rd_meta;
          wr_meta.state  = req.runnable ? rrqs_pkg::ST_READY : rrqs_pkg::ST_BLOCKED;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence each request and register its result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running     <= '0;
      used        <= CNT_W'(1);
      ticks_total <= '0;
      done        <= 1'b0;
      pend_valid  <= 1'b0;
      left        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            req <= request;
            priority case (request.operation)
              rrqs_pkg::OP_TICK:   state <= S_RD_CUR;
              rrqs_pkg::OP_CREATE: state <= S_CREATE;
              rrqs_pkg::OP_SET:    state <= S_SET_RD;
              default:             state <= S_SET_WR;
            endcase
          end
        end
        S_RD_CUR: begin
          cur_idx     <= running;
          ticks_total <= ticks_total + 64'd1;
          state       <= S_UPD_CUR;
        end
        S_UPD_CUR: begin
          cur_word <= bump_word;
          if (rd_meta.quantum > 3'd1) begin
            done   <= 1'b1;
            result <= '{next_context: req.context_value, task_index: to_idx4(cur_idx),
                        status: 1'b0, switched: 1'b0, tick_count: ticks_total,
                        task_count: to_cnt5(used)};
            state  <= S_IDLE;
          end else if (used == CNT_W'(1)) begin
            state <= S_SELF;
          end else begin
            scan_addr  <= step_idx(cur_idx, used);
            left       <= used - CNT_W'(1);
            pend_valid <= 1'b0;
            state      <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // Check the entry read last cycle, issue the next read
          if (pend_valid && rd_meta.state != rrqs_pkg::ST_BLOCKED) begin
            cand_idx  <= pend_addr;
            cand_word <= rd_meta;
            cand_ctx  <= rd_ctx;
            state     <= S_FIN_CAND;
          end else if (left == '0) begin
            state <= S_SELF;
          end else begin
            pend_valid <= 1'b1;
            pend_addr  <= scan_addr;
            scan_addr  <= step_idx(scan_addr, used);
            left       <= left - CNT_W'(1);
          end
        end
        S_SELF: begin
          done   <= 1'b1;
          result <= '{next_context: req.context_value, task_index: to_idx4(cur_idx),
                      status: 1'b0, switched: 1'b0, tick_count: ticks_total,
                      task_count: to_cnt5(used)};
          state  <= S_IDLE;
        end
        S_FIN_CAND: begin
          running <= cand_idx;
          state   <= S_FIN_CUR;
        end
        S_FIN_CUR: begin
          done   <= 1'b1;
          result <= '{next_context: cand_ctx, task_index: to_idx4(cand_idx),
                      status: 1'b0, switched: 1'b1, tick_count: ticks_total,
                      task_count: to_cnt5(used)};
          state  <= S_IDLE;
        end
        S_CREATE: begin
          done <= 1'b1;
          if (table_full) begin
            result <= '{next_context: 64'd0, task_index: 4'd0, status: 1'b1,
                        switched: 1'b0, tick_count: ticks_total,
                        task_count: to_cnt5(used)};
          end else begin
            used   <= used + CNT_W'(1);
            result <= '{next_context: 64'd0, task_index: to_idx4(used[IDX_W-1:0]),
                        status: 1'b0, switched: 1'b0, tick_count: ticks_total,
                        task_count: to_cnt5(used + CNT_W'(1))};
          end
          state <= S_IDLE;
        end
        S_SET_RD: begin
          state <= S_SET_WR;
        end
        S_SET_WR: begin
          done   <= 1'b1;
          result <= '{next_context: 64'd0, task_index: 4'd0, status: 1'b0,
                      switched: 1'b0, tick_count: ticks_total,
                      task_count: to_cnt5(used)};
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_running_in_table: assert property (@(posedge clk) disable iff (rst)
    {{(CNT_W - IDX_W + 1){1'b0}}, running} < {1'b0, used})
    else $error("running task outside the used table");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used != '0 && used <= SLOTS_CNT)
    else $error("task count out of range");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> !wr_ctl.meta_we && !wr_ctl.ctx_we)
    else $error("table written during scan");

  a_cand_differs: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN_CAND |-> cand_idx != cur_idx)
    else $error("switch chose the outgoing task");

  a_switch_result: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN_CAND |=> ##1 done && result.switched)
    else $error("switch did not report a switched result");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int          SLOTS        = 16;
  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam logic [2:0]  QUANTUM_FULL = 3'd4;
  localparam int          RANDOM_REQS  = 1600;
  localparam int          QUIET_TAIL   = 200;
  localparam int          DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  rrqs_pkg::req_t request = '0;
  logic busy;
  logic done;
  rrqs_pkg::rsp_t result;

  // Requests waiting to be sent and results still owed by the block
  rrqs_pkg::req_t sched_req_q[$];
  rrqs_pkg::rsp_t want_rsp_q[$];
  int   total_reqs = 0;
  int   sent_reqs = 0;
  int   gap_left = 0;
  int   mismatches = 0;
  rrqs_pkg::rsp_t want;

  // Scheduler state as the block should hold it
  logic [63:0]           ctx_mem[SLOTS];
  rrqs_pkg::task_state_t state_mem[SLOTS];
  logic [1:0]            prio_mem[SLOTS];
  logic [2:0]            quantum_mem[SLOTS];
  int unsigned run_idx;
  int unsigned used_n;
  logic [63:0] tick_total;

  round_robin_quantum_scheduler u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the scheduler state by one request and return its result
  function automatic rrqs_pkg::rsp_t predict_schedule(rrqs_pkg::req_t rq);
    rrqs_pkg::rsp_t rs;
    int unsigned cur;
    int unsigned cand;
    int unsigned c;
    int unsigned k;
    bit found;
    rs = '0;
    case (rq.operation)
      rrqs_pkg::OP_TICK: begin
        cur = run_idx;
        tick_total = tick_total + 64'd1;
        ctx_mem[cur] = rq.context_value;
        rs.next_context = rq.context_value;
        if (quantum_mem[cur] > 3'd1) begin
          quantum_mem[cur] = quantum_mem[cur] - 3'd1;
        end else begin
          // Walk the table from the slot after the running one
          cand = cur;
          found = 1'b0;
          for (k = 1; k <= used_n && !found; k++) begin
            c = (cur + k) % used_n;
            if (state_mem[c] == rrqs_pkg::ST_READY ||
                state_mem[c] == rrqs_pkg::ST_RUNNING) begin
              cand = c;
              found = 1'b1;
            end
          end
          if (found) begin
            state_mem[cur] = rrqs_pkg::ST_READY;
            run_idx = cand;
            state_mem[cand] = rrqs_pkg::ST_RUNNING;
            rs.next_context = ctx_mem[cand];
            rs.switched = (cand != cur);
          end
          quantum_mem[run_idx] = QUANTUM_FULL - {1'b0, prio_mem[run_idx]};
        end
        rs.task_index = run_idx[3:0];
      end
      rrqs_pkg::OP_CREATE: begin
        if (used_n >= SLOTS) begin
          rs.status = 1'b1;
        end else begin
          ctx_mem[used_n] = rq.context_value;
          state_mem[used_n] = rrqs_pkg::ST_READY;
          prio_mem[used_n] = rq.priority_req;
          quantum_mem[used_n] = QUANTUM_FULL - {1'b0, rq.priority_req};
          rs.task_index = used_n[3:0];
          used_n++;
        end
      end
      rrqs_pkg::OP_SET: begin
        if (rq.task_select < used_n)
          state_mem[rq.task_select] = rq.runnable ? rrqs_pkg::ST_READY :
                                                    rrqs_pkg::ST_BLOCKED;
      end
      default: begin
      end
    endcase
    rs.tick_count = tick_total;
    rs.task_count = used_n[4:0];
    return rs;
  endfunction

  function automatic logic [63:0] rand_context();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '1;
    if (pick == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // Random filler in every field, with the operation given
  function automatic rrqs_pkg::req_t rand_req(logic [1:0] op);
    rrqs_pkg::req_t rq;
    rq.operation = op;
    rq.context_value = rand_context();
    rq.priority_req = 2'($urandom_range(0, 3));
    rq.task_select = 4'($urandom_range(0, 15));
    rq.runnable = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  task automatic flag_mismatch(string what, rrqs_pkg::rsp_t exp_rsp, rrqs_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected ctx=%h idx=%0d status=%0b sw=%0b ticks=%0d tasks=%0d,",
                " actual ctx=%h idx=%0d status=%0b sw=%0b ticks=%0d tasks=%0d"},
               $realtime, what, exp_rsp.next_context, exp_rsp.task_index,
               exp_rsp.status, exp_rsp.switched, exp_rsp.tick_count,
               exp_rsp.task_count, got.next_context, got.task_index, got.status,
               got.switched, got.tick_count, got.task_count);
  endtask

  // Drive requests, predict each one as it is taken, insert idle bursts
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
    end else begin
      if (start && !busy) begin
        want_rsp_q.push_back(predict_schedule(request));
        sent_reqs++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (sched_req_q.size() > QUIET_TAIL &&
                     ((sched_req_q.size() / 100) % 3) != 0 &&
                     $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 4);
          start <= 1'b0;
        end else if (sched_req_q.size() != 0) begin
          request <= sched_req_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result strobe against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (want_rsp_q.size() == 0) begin
        flag_mismatch("result with no request pending", '0, result);
      end else begin
        want = want_rsp_q.pop_front();
        if (result.next_context !== want.next_context ||
            result.task_index !== want.task_index ||
            result.status !== want.status ||
            result.switched !== want.switched ||
            result.tick_count !== want.tick_count ||
            result.task_count !== want.task_count)
          flag_mismatch("result mismatch", want, result);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rrqs_pkg::req_t rq;
    int unsigned gen_used;
    int unsigned pick;
    int i;

    // Scheduler state after reset: task 0 running with a quantum of three
    for (i = 0; i < SLOTS; i++) begin
      ctx_mem[i] = '0;
      state_mem[i] = rrqs_pkg::ST_BLOCKED;
      prio_mem[i] = 2'd0;
      quantum_mem[i] = 3'd0;
    end
    state_mem[0] = rrqs_pkg::ST_RUNNING;
    prio_mem[0] = 2'd1;
    quantum_mem[0] = 3'd3;
    run_idx = 0;
    used_n = 1;
    tick_total = '0;

    // Directed: unused code, select out of range, quantum paths on task 0
    sched_req_q.push_back(rand_req(OP_NONE));
    rq = rand_req(rrqs_pkg::OP_SET);
    rq.task_select = 4'd15;
    rq.runnable = 1'b1;
    sched_req_q.push_back(rq);
    rq = rand_req(rrqs_pkg::OP_TICK);
    rq.context_value = '1;
    sched_req_q.push_back(rq);
    rq = rand_req(rrqs_pkg::OP_TICK);
    rq.context_value = '0;
    sched_req_q.push_back(rq);
    // Expire with only task 0 in the table: task 0 keeps running
    sched_req_q.push_back(rand_req(rrqs_pkg::OP_TICK));
    // Block the running task, then expire with nothing ready
    rq = rand_req(rrqs_pkg::OP_SET);
    rq.task_select = 4'd0;
    rq.runnable = 1'b0;
    sched_req_q.push_back(rq);
    for (i = 0; i < 3; i++)
      sched_req_q.push_back(rand_req(rrqs_pkg::OP_TICK));
    // Fill the table across all priorities, then create once more
    for (i = 0; i < SLOTS; i++) begin
      rq = rand_req(rrqs_pkg::OP_CREATE);
      rq.priority_req = 2'(i);
      if (i == 0) rq.context_value = '1;
      if (i == 1) rq.context_value = '0;
      sched_req_q.push_back(rq);
    end
    gen_used = SLOTS;

    // Random: mostly ticks and state changes, a slow trickle of creates
    for (i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        rq = rand_req(rrqs_pkg::OP_TICK);
      end else if (pick < 94) begin
        rq = rand_req(rrqs_pkg::OP_SET);
        if ($urandom_range(0, 99) < 85)
          rq.task_select = 4'($urandom_range(0, gen_used - 1));
        rq.runnable = ($urandom_range(0, 99) < 65);
      end else if (pick < 98) begin
        rq = rand_req(rrqs_pkg::OP_CREATE);
        if (gen_used < SLOTS) gen_used++;
      end else begin
        rq = rand_req(OP_NONE);
      end
      sched_req_q.push_back(rq);
    end
    total_reqs = sched_req_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every result to come back
    while (sent_reqs < total_reqs) @(posedge clk);
    while (want_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && want_rsp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
